// ===== rtl/core/depth_fog_shader_macros.svh =====
// assertion helpers for the fog shader, clocked on clk, quiet while arst_n is low
`ifndef DEPTH_FOG_SHADER_MACROS_SVH
`define DEPTH_FOG_SHADER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fog shader check failed");

// consequent must hold in the cycle after the antecedent
`define DFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fog shader check failed");

`endif

// ===== rtl/core/dfs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package dfs_pkg;

	// frame width in pixels, columns at or beyond it are clamped to the last one
	localparam int unsigned WIDTH = 160;

	localparam int DEPTH_W = 23;
	localparam int D_W     = DEPTH_W - 1;
	localparam int COLOR_W = 32;
	localparam int XY_W    = 10;
	localparam int MAG_W   = XY_W + 1;
	localparam int FOG_W   = 12;
	localparam int DITH_W  = 4;
	localparam int Q_W     = 16;
	localparam int QQ_W    = 2 * Q_W - 1;
	localparam int F_W     = 17;
	localparam int SIXF_W  = 20;
	localparam int ATT_W   = D_W + SIXF_W;
	localparam int BR_W    = 8;

	localparam logic [XY_W-1:0]  X_MAX   = XY_W'(WIDTH - 1);
	localparam logic [MAG_W-1:0] WIDTH_M = MAG_W'(WIDTH);
	localparam logic [FOG_W-1:0] FOG_RESET = FOG_W'(255);

	// |2x - W| * 2^16 / (2W) as a multiply by a rounded-up reciprocal, exact for
	// numerators below 2^26 and divisors up to 2048
	localparam int RECIP_SHIFT = 37;
	localparam int Q_SHIFT     = RECIP_SHIFT - 16;
	localparam int RECIP_W     = 33;
	localparam longint unsigned RECIP_L =
		((64'd1 << RECIP_SHIFT) + 64'(2 * WIDTH) - 64'd1) / 64'(2 * WIDTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

	typedef struct packed {
		logic [DEPTH_W-1:0] depth;
		logic [COLOR_W-1:0] pixel_color;
		logic [XY_W-1:0]    pixel_x;
		logic [XY_W-1:0]    pixel_y;
	} pix_t;

	typedef struct packed {
		logic               sky;
		logic [COLOR_W-1:0] color;
		logic [D_W-1:0]     depth;
		logic [DITH_W-1:0]  dither;
		logic [QQ_W-1:0]    qq;
	} geom_t;

	typedef struct packed {
		logic               sky;
		logic [COLOR_W-1:0] color;
		logic [BR_W-1:0]    br;
	} bright_t;

	typedef struct packed {
		logic [COLOR_W-1:0] shaded_color;
		logic               is_sky;
	} shade_t;

endpackage
`default_nettype wire

// ===== rtl/core/dfs_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface dfs_pix_if;
	import dfs_pkg::*;

	logic                valid;
	logic                ready;
	logic [DEPTH_W-1:0]  depth;
	logic [COLOR_W-1:0]  pixel_color;
	logic [XY_W-1:0]     pixel_x;
	logic [XY_W-1:0]     pixel_y;

	modport source (output valid, output depth, output pixel_color, output pixel_x,
		output pixel_y, input ready);
	modport sink (input valid, input depth, input pixel_color, input pixel_x,
		input pixel_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dfs_shd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface dfs_shd_if;
	import dfs_pkg::*;

	logic                valid;
	logic                ready;
	logic [COLOR_W-1:0]  shaded_color;
	logic                is_sky;

	modport source (output valid, output shaded_color, output is_sky, input ready);
	modport sink (input valid, input shaded_color, input is_sky, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/dfs_geom.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfs_geom (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire dfs_pkg::pix_t  in_pix,
	output logic                out_valid,
	input  wire logic           out_ready,
	output dfs_pkg::geom_t      out_geom
);
	import dfs_pkg::*;

	logic                v_s1, v_s2, v_s3;
	logic                en_s1, en_s2, en_s3;
	logic                sky_s1, sky_s2, sky_s3;
	logic [COLOR_W-1:0]  color_s1, color_s2, color_s3;
	logic [D_W-1:0]      depth_s1, depth_s2, depth_s3;
	logic [DITH_W-1:0]   dither_s1, dither_s2, dither_s3;
	logic [MAG_W-1:0]    mag_s1;
	logic [Q_W-1:0]      q_s2;
	logic [QQ_W-1:0]     qq_s3;

	logic [XY_W-1:0]     x_clamp;
	logic [MAG_W-1:0]    twox;
	logic [MAG_W-1:0]    mag;
	logic [1:0]          dith_idx;
	logic [MAG_W+RECIP_W-1:0] q_prod;
	logic [2*Q_W-1:0]    sq_prod;

	// stage enables, a stage moves when it is empty or its successor moves
	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// column clamp, distance from centre and dither index
	always_comb begin
		x_clamp  = (in_pix.pixel_x > X_MAX) ? X_MAX : in_pix.pixel_x;
		twox     = {x_clamp, 1'b0};
		mag      = (twox >= WIDTH_M) ? (twox - WIDTH_M) : (WIDTH_M - twox);
		dith_idx = x_clamp[1:0] + {in_pix.pixel_y[0], 1'b0};
	end

	// offset in q16 by reciprocal multiply, then its square
	assign q_prod  = MAG_W'(mag_s1) * RECIP;
	assign sq_prod = q_s2 * q_s2;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			sky_s1    <= in_pix.depth[DEPTH_W-1];
			color_s1  <= in_pix.pixel_color;
			depth_s1  <= in_pix.depth[D_W-1:0];
			dither_s1 <= {dith_idx, 2'b00};
			mag_s1    <= mag;
		end
		if (en_s2) begin
			sky_s2    <= sky_s1;
			color_s2  <= color_s1;
			depth_s2  <= depth_s1;
			dither_s2 <= dither_s1;
			q_s2      <= q_prod[Q_SHIFT+Q_W-1:Q_SHIFT];
		end
		if (en_s3) begin
			sky_s3    <= sky_s2;
			color_s3  <= color_s2;
			depth_s3  <= depth_s2;
			dither_s3 <= dither_s2;
			qq_s3     <= sq_prod[QQ_W-1:0];
		end
	end

	assign out_valid = v_s3;
	always_comb begin
		out_geom.sky    = sky_s3;
		out_geom.color  = color_s3;
		out_geom.depth  = depth_s3;
		out_geom.dither = dither_s3;
		out_geom.qq     = qq_s3;
	end
endmodule
`default_nettype wire

// ===== rtl/core/dfs_atten.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfs_atten (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [dfs_pkg::FOG_W-1:0]  fog_level,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire dfs_pkg::geom_t             in_geom,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output dfs_pkg::bright_t                out_bright
);
	import dfs_pkg::*;

	localparam int S_W   = ATT_W + 1;
	localparam int FL_W  = S_W - 24;
	localparam int SUM_W = FL_W + 1;

	logic                v_s4, v_s5;
	logic                en_s4, en_s5;
	logic                sky_s4, sky_s5;
	logic [COLOR_W-1:0]  color_s4, color_s5;
	logic [DITH_W-1:0]   dither_s4;
	logic [ATT_W-1:0]    att_s4;
	logic [BR_W-1:0]     br_s5;

	logic [F_W-1:0]      factor;
	logic [SIXF_W-1:0]   six_f;
	logic [S_W-1:0]      diff;
	logic [FL_W-1:0]     fl;
	logic                round_up;
	logic [SUM_W-1:0]    sum;
	logic [BR_W-1:0]     br;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	// horizontal factor 1 + 2q^2 in q16, times six, times depth
	always_comb begin
		factor = F_W'(65536) + F_W'(in_geom.qq[QQ_W-1:15]);
		six_f  = (SIXF_W'(factor) << 2) + (SIXF_W'(factor) << 1);
	end

	// fog minus attenuation, truncate toward zero, add dither, floor and clamp
	always_comb begin
		diff     = S_W'({fog_level, 24'd0}) - S_W'(att_s4);
		fl       = diff[S_W-1:24];
		round_up = diff[S_W-1] && (|diff[23:0]);
		sum      = {fl[FL_W-1], fl} + SUM_W'(round_up) + SUM_W'(dither_s4);
		if (sum[SUM_W-1]) begin
			br = '0;
		end else if (|sum[SUM_W-2:BR_W]) begin
			br = BR_W'(255);
		end else begin
			br = {sum[BR_W-1:4], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sky_s4    <= in_geom.sky;
			color_s4  <= in_geom.color;
			dither_s4 <= in_geom.dither;
			att_s4    <= in_geom.depth * six_f;
		end
		if (en_s5) begin
			sky_s5   <= sky_s4;
			color_s5 <= color_s4;
			br_s5    <= br;
		end
	end

	assign out_valid = v_s5;
	always_comb begin
		out_bright.sky   = sky_s5;
		out_bright.color = color_s5;
		out_bright.br    = br_s5;
	end
endmodule
`default_nettype wire

// ===== rtl/core/dfs_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module dfs_scale (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire dfs_pkg::bright_t  in_bright,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output dfs_pkg::shade_t        out_shade
);
	import dfs_pkg::*;

	localparam int P_W = 2 * BR_W;

	logic                v_s6, v_s7;
	logic                en_s6, en_s7;
	logic                sky_s6;
	logic [COLOR_W-1:0]  color_s6;
	logic [P_W-1:0]      pr_s6, pg_s6, pb_s6;
	shade_t              shade_s7;

	// floor(p / 255) for p up to 255 * 255
	function automatic logic [BR_W-1:0] div255(input logic [P_W-1:0] p);
		logic [P_W:0] t;
		t = (P_W+1)'(p) + (P_W+1)'(p >> 8) + (P_W+1)'(1);
		return t[P_W-1:BR_W];
	endfunction

	assign en_s7    = !v_s7 || out_ready;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= in_valid;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	// channel products, then divide and pack with alpha cleared; sky pixels keep their colour
	always_ff @(posedge clk) begin
		if (en_s6) begin
			sky_s6   <= in_bright.sky;
			color_s6 <= in_bright.color;
			pr_s6    <= in_bright.color[23:16] * in_bright.br;
			pg_s6    <= in_bright.color[15:8] * in_bright.br;
			pb_s6    <= in_bright.color[7:0] * in_bright.br;
		end
		if (en_s7) begin
			shade_s7.is_sky <= sky_s6;
			if (sky_s6) begin
				shade_s7.shaded_color <= color_s6;
			end else begin
				shade_s7.shaded_color <= {8'h00, div255(pr_s6), div255(pg_s6),
					div255(pb_s6)};
			end
		end
	end

	assign out_valid = v_s7;
	assign out_shade = shade_s7;
endmodule
`default_nettype wire

// ===== rtl/core/depth_fog_shader.sv =====
// depth fog shader: distance fog with ordered dither, one pixel per beat
// throughput: one pixel per cycle; each pipeline stage stalls only when full
//   and its successor is stalled
// reset: arst_n clears all valid bits at once and sets fog_level to 255
`timescale 1ns / 1ps
`default_nettype none
`include "depth_fog_shader_macros.svh"
module depth_fog_shader (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	dfs_pix_if.sink                         pixel,
	dfs_shd_if.source                       shade,
	input  wire logic                       cfg_we,
	input  wire logic [dfs_pkg::FOG_W-1:0]  cfg_wdata
);
	import dfs_pkg::*;

	logic [FOG_W-1:0]  fog_q;
	pix_t              pix;
	logic              geom_valid, geom_ready;
	geom_t             geom;
	logic              bright_valid, bright_ready;
	bright_t           bright;
	shade_t            shd;

	// fog level register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fog_q <= FOG_RESET;
		end else if (cfg_we) begin
			fog_q <= cfg_wdata;
		end
	end

	always_comb begin
		pix.depth       = pixel.depth;
		pix.pixel_color = pixel.pixel_color;
		pix.pixel_x     = pixel.pixel_x;
		pix.pixel_y     = pixel.pixel_y;
	end

	// stages 1 to 3: column geometry and squared horizontal offset
	dfs_geom u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.in_pix    (pix),
		.out_valid (geom_valid),
		.out_ready (geom_ready),
		.out_geom  (geom)
	);

	// stages 4 and 5: attenuation and brightness
	dfs_atten u_atten (
		.clk        (clk),
		.arst_n     (arst_n),
		.fog_level  (fog_q),
		.in_valid   (geom_valid),
		.in_ready   (geom_ready),
		.in_geom    (geom),
		.out_valid  (bright_valid),
		.out_ready  (bright_ready),
		.out_bright (bright)
	);

	// stages 6 and 7: channel scaling and output register
	dfs_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bright_valid),
		.in_ready  (bright_ready),
		.in_bright (bright),
		.out_valid (shade.valid),
		.out_ready (shade.ready),
		.out_shade (shd)
	);

	assign shade.shaded_color = shd.shaded_color;
	assign shade.is_sky       = shd.is_sky;

	// a ready sink downstream lets every stage move, so input is never held off
	`DFS_ASSERT_IMP(a_ready_through, shade.ready, pixel.ready)
	// fogged pixels always leave with alpha cleared
	`DFS_ASSERT_IMP(a_alpha_clear, shade.valid && !shade.is_sky,
		shade.shaded_color[31:24] == 8'h00)
	// a register write lands in the next cycle
	`DFS_ASSERT_NXT(a_fog_write, cfg_we, fog_q == $past(cfg_wdata))
endmodule
`default_nettype wire
